// ===== rtl/core/cfft_pkg.sv =====
// Shared constants, types and helpers for the radix-2 FFT core.
// Holds the twiddle table builder and saturation helpers; no dependencies.
package cfft_pkg;

  localparam int MAX_LOG2_POINTS = 10;
  localparam int SAMPLE_BITS     = 16;
  localparam int WORD_BITS       = 28;
  localparam int NPTS            = 1 << MAX_LOG2_POINTS;
  localparam int ROM_LEN         = NPTS / 2;
  localparam int ROM_BITS        = MAX_LOG2_POINTS - 1;
  localparam int TW_BITS         = 17;
  localparam int PROD_BITS       = WORD_BITS + TW_BITS;
  localparam int WIDE_BITS       = 48;
  localparam int CFG_DATA_BITS   = 4;
  localparam int CFG_IDX_BITS    = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_LOG2_SIZE    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INVERSE_MODE = 2'd1;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [TW_BITS-1:0]   tw_t;
  typedef logic signed [WIDE_BITS-1:0] wide_t;
  typedef tw_t tw_tab_t [ROM_LEN];

  // Clamp a wide value to the signed storage word
  function automatic word_t sat_word(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (WORD_BITS - 1)) - wide_t'(1);
    lo = -(wide_t'(1) <<< (WORD_BITS - 1));
    if (v > hi) return word_t'(hi);
    if (v < lo) return word_t'(lo);
    return word_t'(v);
  endfunction

  // Unsigned quotient by shift and subtract; only used while building tables
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Build cosine (want_sin = 0) or sine table, Q15, over the first half turn
  function automatic tw_tab_t build_tw(input bit want_sin);
    tw_tab_t tab;
    longint unsigned kk, x, x2, ts, tc, ss, sc;
    longint signed cq, sq, t;
    bit neg, swap;
    for (int k = 0; k < ROM_LEN; k++) begin
      kk = longint'(k);
      neg = 1'b0;
      swap = 1'b0;
      if (4 * kk > NPTS) begin
        kk = NPTS / 2 - kk;
        neg = 1'b1;
      end
      if (8 * kk > NPTS) begin
        kk = NPTS / 4 - kk;
        swap = 1'b1;
      end
      x = (PI_Q30 * 2 * kk) >> MAX_LOG2_POINTS;
      x2 = (x * x) >> 30;
      ts = x;
      ss = x;
      tc = ONE_Q30;
      sc = ONE_Q30;
      for (int n = 1; n <= 5; n++) begin
        ts = udiv((ts * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
        tc = udiv((tc * x2) >> 30, 64'((2 * n - 1) * (2 * n)));
        if (n % 2 == 1) begin
          ss = ss - ts;
          sc = sc - tc;
        end else begin
          ss = ss + ts;
          sc = sc + tc;
        end
      end
      cq = longint'((sc + 64'd16384) >> 15);
      sq = longint'((ss + 64'd16384) >> 15);
      if (swap) begin
        t = cq;
        cq = sq;
        sq = t;
      end
      if (neg) cq = -cq;
      tab[k] = want_sin ? tw_t'(sq) : tw_t'(cq);
    end
    return tab;
  endfunction

endpackage

// ===== rtl/core/complex_radix2_fft.sv =====
// In-place radix-2 decimation-in-time FFT core over one point memory.
// Depends on cfft_pkg for widths, twiddle table and saturation.
//
// Load transactions (op 0) fill the frame one point each; the load of the
// last point starts the transform, during which busy stays high.
// The bit-reverse pass reads, captures and writes back each swapped pair
// (and each self-reversed point in inverse mode) and leaves all other
// points in place. Then log2(N) stages of N/2 butterflies follow, each
// going through read, multiply, add, and two writes through the single
// write port of the point memory. A read transaction (op 1) raises busy
// while the core passes through its output state; the bin is read through
// the registered memory port and the registered output stage and appears
// with bin_valid for exactly one cycle; results cannot be stalled. Reads
// with no frame ready return nothing.
// Configuration writes are taken at any time but belong in idle periods.
module complex_radix2_fft
  import cfft_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     start,
  output logic                     busy,
  input  logic                     op,
  input  logic signed [SAMPLE_BITS-1:0] sample_re,
  input  logic signed [SAMPLE_BITS-1:0] sample_im,
  output logic                     bin_valid,
  output logic signed [WORD_BITS-1:0] bin_re,
  output logic signed [WORD_BITS-1:0] bin_im,
  output logic                     last_bin
);

  localparam int AW = MAX_LOG2_POINTS;
  localparam int LW = 4;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RDOUT  = 4'd1;
  localparam logic [3:0] S_BR_RD  = 4'd2;
  localparam logic [3:0] S_BR_CAP = 4'd3;
  localparam logic [3:0] S_BR_WA  = 4'd4;
  localparam logic [3:0] S_BR_WB  = 4'd5;
  localparam logic [3:0] S_BF_RD  = 4'd6;
  localparam logic [3:0] S_BF_MUL = 4'd7;
  localparam logic [3:0] S_BF_ADD = 4'd8;
  localparam logic [3:0] S_BF_WA  = 4'd9;
  localparam logic [3:0] S_BF_WB  = 4'd10;

  localparam tw_tab_t TW_COS = build_tw(1'b0);
  localparam tw_tab_t TW_SIN = build_tw(1'b1);

  // Point memory
  word_t mem_re [NPTS];
  word_t mem_im [NPTS];

  logic [3:0]    state;
  logic [LW-1:0] log2_size;
  logic          inverse_mode;
  logic          inv_frame;
  logic          frame_ready;
  logic          out_pending;
  logic          out_last;
  logic [AW-1:0] load_index;
  logic [AW-1:0] read_index;
  logic [AW-1:0] br_i;
  logic [AW-1:0] br_r;
  logic [LW-1:0] stage;
  logic [AW-2:0] bf_k;

  logic [AW-1:0] ra_a, ra_b, wa;
  logic          we;
  word_t         wd_re, wd_im;
  word_t         rda_re, rda_im, rdb_re, rdb_im;
  word_t         pa_re, pa_im, pb_re, pb_im;
  tw_t           tw_c, tw_s;
  logic signed [PROD_BITS-1:0] p_rc, p_is, p_ic, p_rs;
  word_t         top_re, top_im, bot_re, bot_im;

  logic [AW-1:0] mask_n;
  logic [AW-1:0] rev_full, rev_i;
  logic [AW-1:0] half_m, bf_j, bf_i, bf_p, k_ext;
  logic [ROM_BITS-1:0] tw_idx;
  logic          br_work;
  logic          accept;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign mask_n = {AW{1'b1}} >> (AW - int'(log2_size));

  // Bit reversal of the point index over the frame size
  always_comb begin
    for (int b = 0; b < AW; b++) rev_full[b] = br_i[AW-1-b];
    rev_i = rev_full >> (AW - int'(log2_size));
  end
  assign br_work = (br_i < rev_i) || ((br_i == rev_i) && inv_frame);

  // Butterfly addressing for the current stage and butterfly count
  always_comb begin
    k_ext  = {1'b0, bf_k};
    half_m = AW'(1) << (stage - LW'(1));
    bf_j   = k_ext & (half_m - AW'(1));
    bf_i   = ((k_ext >> (stage - LW'(1))) << stage) | bf_j;
    bf_p   = bf_i | half_m;
    tw_idx = ROM_BITS'(bf_j << (LW'(AW) - stage));
  end

  // Read address selection
  always_comb begin
    unique case (state)
      S_BR_RD: begin
        ra_a = br_i;
        ra_b = rev_i;
      end
      S_BF_RD: begin
        ra_a = bf_i;
        ra_b = bf_p;
      end
      default: begin
        ra_a = read_index;
        ra_b = read_index;
      end
    endcase
  end

  // Write port selection
  always_comb begin
    we    = 1'b0;
    wa    = load_index;
    wd_re = word_t'(sample_re);
    wd_im = word_t'(sample_im);
    unique case (state)
      S_IDLE: begin
        we = accept && !op;
        wa = frame_ready ? '0 : load_index;
      end
      S_BR_WA: begin
        we    = 1'b1;
        wa    = br_i;
        wd_re = pb_re;
        wd_im = pb_im;
      end
      S_BR_WB: begin
        we    = 1'b1;
        wa    = br_r;
        wd_re = pa_re;
        wd_im = pa_im;
      end
      S_BF_WA: begin
        we    = 1'b1;
        wa    = bf_i;
        wd_re = top_re;
        wd_im = top_im;
      end
      S_BF_WB: begin
        we    = 1'b1;
        wa    = bf_p;
        wd_re = bot_re;
        wd_im = bot_im;
      end
      default: ;
    endcase
  end

  // Memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem_re[wa] <= wd_re;
      mem_im[wa] <= wd_im;
    end
    rda_re <= mem_re[ra_a];
    rda_im <= mem_im[ra_a];
    rdb_re <= mem_re[ra_b];
    rdb_im <= mem_im[ra_b];
  end

  // Twiddle ROM, registered read
  always_ff @(posedge clk) begin
    tw_c <= TW_COS[tw_idx];
    tw_s <= TW_SIN[tw_idx];
  end

  // Datapath registers for swaps and butterflies
  always_ff @(posedge clk) begin
    if (state == S_BR_CAP) begin
      pa_re <= rda_re;
      pb_re <= rdb_re;
      pa_im <= inv_frame ? sat_word(-wide_t'(rda_im)) : rda_im;
      pb_im <= inv_frame ? sat_word(-wide_t'(rdb_im)) : rdb_im;
    end
    if (state == S_BF_MUL) begin
      pa_re <= rda_re;
      pa_im <= rda_im;
      p_rc  <= PROD_BITS'(rdb_re * tw_c);
      p_is  <= PROD_BITS'(rdb_im * tw_s);
      p_ic  <= PROD_BITS'(rdb_im * tw_c);
      p_rs  <= PROD_BITS'(rdb_re * tw_s);
    end
    if (state == S_BF_ADD) begin
      top_re <= sat_word(wide_t'(pa_re) + ((wide_t'(p_rc) + wide_t'(p_is) + 48'sd16384) >>> 15));
      top_im <= sat_word(wide_t'(pa_im) + ((wide_t'(p_ic) - wide_t'(p_rs) + 48'sd16384) >>> 15));
      bot_re <= sat_word(wide_t'(pa_re) - ((wide_t'(p_rc) + wide_t'(p_is) + 48'sd16384) >>> 15));
      bot_im <= sat_word(wide_t'(pa_im) - ((wide_t'(p_ic) - wide_t'(p_rs) + 48'sd16384) >>> 15));
    end
    if (state == S_BR_RD) br_r <= rev_i;
  end

  // Output stage: undo conjugation and scale in inverse mode
  always_ff @(posedge clk) begin
    if (state == S_RDOUT) begin
      if (inv_frame) begin
        bin_re <= sat_word((wide_t'(rda_re) + (wide_t'(1) <<< (log2_size - LW'(1))))
                           >>> log2_size);
        bin_im <= sat_word((-wide_t'(rda_im) + (wide_t'(1) <<< (log2_size - LW'(1))))
                           >>> log2_size);
      end else begin
        bin_re <= rda_re;
        bin_im <= rda_im;
      end
      last_bin <= out_last;
    end
  end

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      log2_size    <= LW'(MAX_LOG2_POINTS);
      inverse_mode <= 1'b0;
      inv_frame    <= 1'b0;
      frame_ready  <= 1'b0;
      out_pending  <= 1'b0;
      out_last     <= 1'b0;
      bin_valid    <= 1'b0;
      load_index   <= '0;
      read_index   <= '0;
      br_i         <= '0;
      stage        <= LW'(1);
      bf_k         <= '0;
    end else begin
      bin_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_LOG2_SIZE) begin
          if (cfg_data == '0) log2_size <= LW'(1);
          else if (cfg_data > CFG_DATA_BITS'(MAX_LOG2_POINTS))
            log2_size <= LW'(MAX_LOG2_POINTS);
          else log2_size <= LW'(cfg_data);
          load_index  <= '0;
          read_index  <= '0;
          frame_ready <= 1'b0;
        end else if (cfg_index == REG_INVERSE_MODE) begin
          inverse_mode <= cfg_data[0];
        end
      end
      unique case (state)
        S_IDLE: begin
          if (accept && !op) begin
            // Store the sample; start the transform on the last point
            if (frame_ready) begin
              frame_ready <= 1'b0;
              read_index  <= '0;
            end
            if ((frame_ready ? '0 : load_index) == mask_n) begin
              load_index <= '0;
              inv_frame  <= inverse_mode;
              br_i       <= '0;
              state      <= S_BR_RD;
            end else begin
              load_index <= (frame_ready ? '0 : load_index) + AW'(1);
            end
          end else if (accept && op) begin
            out_pending <= frame_ready;
            out_last    <= (read_index == mask_n);
            state       <= S_RDOUT;
            if (frame_ready) begin
              if (read_index == mask_n) begin
                read_index  <= '0;
                frame_ready <= 1'b0;
              end else begin
                read_index <= read_index + AW'(1);
              end
            end
          end
        end
        S_RDOUT: begin
          bin_valid <= out_pending;
          state     <= S_IDLE;
        end
        S_BR_RD: begin
          if (br_work) begin
            state <= S_BR_CAP;
          end else if (br_i == mask_n) begin
            stage <= LW'(1);
            bf_k  <= '0;
            state <= S_BF_RD;
          end else begin
            br_i <= br_i + AW'(1);
          end
        end
        S_BR_CAP: state <= S_BR_WA;
        S_BR_WA:  state <= S_BR_WB;
        S_BR_WB: begin
          if (br_i == mask_n) begin
            stage <= LW'(1);
            bf_k  <= '0;
            state <= S_BF_RD;
          end else begin
            br_i  <= br_i + AW'(1);
            state <= S_BR_RD;
          end
        end
        S_BF_RD:  state <= S_BF_MUL;
        S_BF_MUL: state <= S_BF_ADD;
        S_BF_ADD: state <= S_BF_WA;
        S_BF_WA:  state <= S_BF_WB;
        S_BF_WB: begin
          // Advance to the next butterfly, stage, or finish the frame
          if (bf_k == mask_n[AW-1:1]) begin
            bf_k <= '0;
            if (stage == log2_size) begin
              frame_ready <= 1'b1;
              read_index  <= '0;
              state       <= S_IDLE;
            end else begin
              stage <= stage + LW'(1);
              state <= S_BF_RD;
            end
          end else begin
            bf_k  <= bf_k + (AW-1)'(1);
            state <= S_BF_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/cfft_checker.sv =====
// Port-level checker for the FFT core, bound to complex_radix2_fft.
// Depends on cfft_pkg for port widths.
module cfft_checker
  import cfft_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     cfg_we,
  input logic [CFG_IDX_BITS-1:0]  cfg_index,
  input logic [CFG_DATA_BITS-1:0] cfg_data,
  input logic                     start,
  input logic                     busy,
  input logic                     op,
  input logic signed [SAMPLE_BITS-1:0] sample_re,
  input logic signed [SAMPLE_BITS-1:0] sample_im,
  input logic                     bin_valid,
  input logic signed [WORD_BITS-1:0] bin_re,
  input logic signed [WORD_BITS-1:0] bin_im,
  input logic                     last_bin
);

  // A bin only ever follows a read transaction
  a_bin_from_read: assert property (@(posedge clk) disable iff (rst)
    bin_valid |-> $past(start && !busy && op, 2))
    else $error("bin without a read transaction");

  // Bins never come on back-to-back cycles
  a_bin_spacing: assert property (@(posedge clk) disable iff (rst)
    bin_valid |=> !bin_valid)
    else $error("bins on consecutive cycles");

  // A read transaction raises busy and so holds off the next one
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op) |=> busy)
    else $error("read transaction did not raise busy");

  // A load transaction never produces a bin
  a_load_no_bin: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !op) |=> ##1 !bin_valid)
    else $error("load transaction produced a bin");

endmodule

bind complex_radix2_fft cfft_checker u_cfft_checker (.*);
